### rtl/dss_pkg.sv
// ----------------------------------------------------------------------------
// Discrete state-space step package
// Shared widths, coefficient types and configuration register indexes.
// ----------------------------------------------------------------------------
package dss_pkg;

  // Number of lanes in each packed A-row, B and C coefficient register.
  localparam int LANES       = 4;
  // Default model order; lanes at or above it carry no state.
  localparam int ORDER_DEF   = 4;
  localparam int COEF_W      = 16;
  localparam int FRAC_BITS   = 14;
  localparam int SAMPLE_W    = 16;
  localparam int STATE_W     = 24;
  localparam int CFG_DATA_W  = LANES * COEF_W;
  localparam int CFG_INDEX_W = 3;

  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [STATE_W-1:0]  state_t;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_A_ROW0    = 3'd0,
    REG_A_ROW1    = 3'd1,
    REG_A_ROW2    = 3'd2,
    REG_A_ROW3    = 3'd3,
    REG_B_VECTOR  = 3'd4,
    REG_C_VECTOR  = 3'd5,
    REG_D_GAIN    = 3'd6
  } reg_index_t;

  // Complete coefficient set handed from the register file to the datapath.
  typedef struct packed {
    coef_t [LANES-1:0][LANES-1:0] a;
    coef_t [LANES-1:0]            b;
    coef_t [LANES-1:0]            c;
    coef_t                        d;
  } coef_set_t;

endpackage

### rtl/dss_cfg.sv
// ----------------------------------------------------------------------------
// Coefficient register file
// Holds the A matrix, B and C vectors and the D gain; written by index.
// ----------------------------------------------------------------------------
module dss_cfg
  import dss_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output coef_set_t              coefs
);

  coef_set_t regs;

  // Register writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_A_ROW0:   regs.a[0] <= cfg_wdata;
        REG_A_ROW1:   regs.a[1] <= cfg_wdata;
        REG_A_ROW2:   regs.a[2] <= cfg_wdata;
        REG_A_ROW3:   regs.a[3] <= cfg_wdata;
        REG_B_VECTOR: regs.b    <= cfg_wdata;
        REG_C_VECTOR: regs.c    <= cfg_wdata;
        REG_D_GAIN:   regs.d    <= cfg_wdata[COEF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign coefs = regs;

endmodule

### rtl/dss_dot.sv
// ----------------------------------------------------------------------------
// Dot-product lane
// Computes sat24((coef . x + gain * u) >>> FRAC_BITS) in one pass.
// ----------------------------------------------------------------------------
module dss_dot
  import dss_pkg::*;
(
  input  coef_t [LANES-1:0]  coef,
  input  state_t [LANES-1:0] x,
  input  coef_t              gain,
  input  sample_t            u,
  output state_t             result
);

  localparam int PROD_W = COEF_W + STATE_W;
  localparam int ACC_W  = PROD_W + 3;
  localparam int SH_W   = ACC_W - FRAC_BITS;

  logic signed [PROD_W-1:0] prod [LANES];
  logic signed [PROD_W-1:0] prod_u;
  logic signed [ACC_W-1:0]  acc;
  logic signed [SH_W-1:0]   shifted;
  logic [SH_W-STATE_W:0]    top_bits;

  // One product per lane plus the input term, all in parallel.
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      prod[k] = PROD_W'(coef[k]) * PROD_W'(x[k]);
    end
    prod_u = PROD_W'(gain) * PROD_W'(u);
  end

  // Full-precision sum of the five products.
  always_comb begin
    acc = ACC_W'(prod_u);
    for (int k = 0; k < LANES; k++) begin
      acc = acc + ACC_W'(prod[k]);
    end
  end

  // Arithmetic shift, then saturate when the upper bits disagree.
  assign shifted  = SH_W'(acc >>> FRAC_BITS);
  assign top_bits = shifted[SH_W-1:STATE_W-1];

  always_comb begin
    if ((&top_bits) || !(|top_bits)) begin
      result = shifted[STATE_W-1:0];
    end else if (shifted[SH_W-1]) begin
      result = {1'b1, {(STATE_W-1){1'b0}}};
    end else begin
      result = {1'b0, {(STATE_W-1){1'b1}}};
    end
  end

endmodule

### rtl/discrete_state_space_step.sv
// A beat is held in the input register, then its result is registered in the output register.
// Throughput: one beat per cycle while the output is not stalled; the state update is
// combinational through five multiplies and a five-term add per lane.
// Reset clears the state vector, all coefficients and both valid flags.
// ----------------------------------------------------------------------------
// Discrete state-space step
// Single-input, single-output state-space model: y = C.x + D.u, x' = A.x + B.u.
// ----------------------------------------------------------------------------
module discrete_state_space_step
  import dss_pkg::*;
#(
  parameter int STATE_ORDER = ORDER_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // Input stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [SAMPLE_W-1:0]    s_tdata,   // [15:0] sample_in
  // Output stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [STATE_W-1:0]     m_tdata,   // [23:0] sample_out
  // Configuration write port
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  coef_set_t          coefs;
  logic               in_valid;
  sample_t            in_sample;
  logic               advance;
  state_t [LANES-1:0] state_q;
  state_t [LANES-1:0] state_next;
  state_t             y;
  state_t             out_sample;

  dss_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .coefs     (coefs)
  );

  // Input register: holds one beat until the output register can take it.
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_sample <= s_tdata;
    end
  end

  // Output from the old state.
  dss_dot u_out (
    .coef   (coefs.c),
    .x      (state_q),
    .gain   (coefs.d),
    .u      (in_sample),
    .result (y)
  );

  // State lanes: only the first STATE_ORDER lanes carry state.
  for (genvar i = 0; i < LANES; i++) begin : g_lane
    if (i < STATE_ORDER) begin : g_used
      dss_dot u_row (
        .coef   (coefs.a[i]),
        .x      (state_q),
        .gain   (coefs.b[i]),
        .u      (in_sample),
        .result (state_next[i])
      );
    end else begin : g_unused
      assign state_next[i] = '0;
    end
  end

  // State register; unused lanes reset to zero and reload zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_sample <= y;
    end
  end

  assign m_tdata = out_sample;

endmodule
